// ===== sv/pan_tilt_aim_controller_top_assert.svh =====
// assertion macros used by the aim controller's pta_ctrl module
`ifndef PAN_TILT_AIM_CONTROLLER_TOP_ASSERT_SVH
`define PAN_TILT_AIM_CONTROLLER_TOP_ASSERT_SVH

`ifndef SYNTHESIS
// same-cycle implication, checked on every rising clock edge outside reset
`define PTA_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("pta assertion failed");
// next-cycle implication
`define PTA_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("pta assertion failed");
`else
`define PTA_ASSERT_NOW(lbl, ante, cons)
`define PTA_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

// ===== sv/pta_pkg.sv =====
// shared types, constants and helpers for the pan/tilt aim controller
`default_nettype none

package pta_pkg;

  localparam int SHOT_TOTAL = 3;

  localparam int POS_W   = 22;
  localparam int PIX_W   = 12;
  localparam int GAIN_W  = 8;
  localparam int MISS_W  = 8;
  localparam int SHOT_W  = 2;
  localparam int CFG_W   = 44;
  localparam int CFG_IDX_W = 3;

  // register reset values
  localparam logic [23:0] THRESH_RST  = 24'h00A00A;
  localparam logic [15:0] GAINS_RST   = 16'h0101;
  localparam logic [35:0] AIM_RST     = 36'h0;
  localparam logic [43:0] LIMITS_RST  = {22'h3FFFFF, 22'h000000};
  localparam logic [43:0] HOME_RST    = 44'h0;
  localparam logic [7:0]  LOST_RST    = 8'd10;

  typedef enum logic [1:0] {
    KIND_TARGET = 2'd0,
    KIND_MISS   = 2'd1,
    KIND_ACK    = 2'd2
  } kind_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_THRESH    = 3'd0,
    REG_GAINS     = 3'd1,
    REG_AIM_X     = 3'd2,
    REG_AIM_Y     = 3'd3,
    REG_PAN_LIM   = 3'd4,
    REG_TILT_LIM  = 3'd5,
    REG_HOME      = 3'd6,
    REG_LOST      = 3'd7
  } cfg_idx_t;

  // held input item
  typedef struct packed {
    logic [1:0]       kind;
    logic [PIX_W-1:0] centroid_x;
    logic [PIX_W-1:0] centroid_y;
  } item_t;

  // per-axis step result back to the controller
  typedef struct packed {
    logic             in_win;
    logic [POS_W-1:0] move_pos;
  } axis_res_t;

  // aim point of the current barrel; a count of three wraps to barrel one
  function automatic logic [PIX_W-1:0] pick_point(input logic [3*PIX_W-1:0] pts,
                                                  input logic [SHOT_W-1:0] shot);
    logic [PIX_W-1:0] p;
    case (shot)
      2'd1:    p = pts[2*PIX_W-1:PIX_W];
      2'd2:    p = pts[3*PIX_W-1:2*PIX_W];
      default: p = pts[PIX_W-1:0];
    endcase
    return p;
  endfunction

endpackage

`default_nettype wire

// ===== sv/pta_if.sv =====
// item channel interfaces for camera input and servo command output
`default_nettype none

interface pta_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [11:0] centroid_x;
  logic [11:0] centroid_y;

  modport source (output valid, kind, centroid_x, centroid_y, input ready);
  modport sink   (input valid, kind, centroid_x, centroid_y, output ready);
endinterface

interface pta_out_if;
  logic        valid;
  logic        ready;
  logic [21:0] pan_command;
  logic [21:0] tilt_command;
  logic        pan_moved;
  logic        tilt_moved;
  logic        fire_request;
  logic [1:0]  shots_done;
  logic        finished;

  modport source (output valid, pan_command, tilt_command, pan_moved, tilt_moved,
                  fire_request, shots_done, finished, input ready);
  modport sink   (input valid, pan_command, tilt_command, pan_moved, tilt_moved,
                  fire_request, shots_done, finished, output ready);
endinterface

`default_nettype wire

// ===== sv/pta_axis.sv =====
// one axis: error against aim point, threshold compare, gain step and clamp
`default_nettype none

module pta_axis (
  input  wire logic [pta_pkg::POS_W-1:0]  pos,
  input  wire logic [pta_pkg::PIX_W-1:0]  aim,
  input  wire logic [pta_pkg::PIX_W-1:0]  centroid,
  input  wire logic [pta_pkg::PIX_W-1:0]  thresh,
  input  wire logic [pta_pkg::GAIN_W-1:0] gain,
  input  wire logic [2*pta_pkg::POS_W-1:0] limits,
  output pta_pkg::axis_res_t              res
);

  logic signed [12:0] err;
  logic        [12:0] err_abs;
  logic signed [20:0] gain_ext;
  logic signed [20:0] err_ext;
  logic signed [20:0] prod;
  logic signed [23:0] sum;
  logic signed [23:0] lo_ext;
  logic signed [23:0] hi_ext;
  logic               over;

  // signed error and its magnitude
  assign err     = $signed({1'b0, aim}) - $signed({1'b0, centroid});
  assign err_abs = err[12] ? 13'(-err) : err;
  assign over    = err_abs > {1'b0, thresh};

  // gain times error, applied only above threshold
  assign gain_ext = {{13{gain[7]}}, gain};
  assign err_ext  = {{8{err[12]}}, err};
  assign prod     = gain_ext * err_ext;
  assign sum      = $signed({2'b00, pos}) + (over ? {{3{prod[20]}}, prod} : 24'sd0);

  // clamp, minimum checked first
  assign lo_ext = $signed({2'b00, limits[pta_pkg::POS_W-1:0]});
  assign hi_ext = $signed({2'b00, limits[2*pta_pkg::POS_W-1:pta_pkg::POS_W]});

  always_comb begin
    res.in_win = err_abs < {1'b0, thresh};
    if (sum < lo_ext) begin
      res.move_pos = lo_ext[pta_pkg::POS_W-1:0];
    end else if (sum > hi_ext) begin
      res.move_pos = hi_ext[pta_pkg::POS_W-1:0];
    end else begin
      res.move_pos = sum[pta_pkg::POS_W-1:0];
    end
  end

endmodule

`default_nettype wire

// ===== sv/pta_ctrl.sv =====
// input register, tracking state, fire handshake and result register
`default_nettype none
`include "pan_tilt_aim_controller_top_assert.svh"

module pta_ctrl (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  pta_in_if.sink                             in_ch,
  pta_out_if.source                          out_ch,
  input  wire logic [2*pta_pkg::POS_W-1:0]   home,
  input  wire logic [pta_pkg::MISS_W-1:0]    lost_limit,
  input  wire pta_pkg::axis_res_t            pan_res,
  input  wire pta_pkg::axis_res_t            tilt_res,
  output pta_pkg::item_t                     item,
  output logic [pta_pkg::POS_W-1:0]          pan_pos,
  output logic [pta_pkg::POS_W-1:0]          tilt_pos,
  output logic [pta_pkg::SHOT_W-1:0]         shot_count
);

  pta_pkg::item_t              item_r;
  logic                        item_vld_r;
  logic [pta_pkg::POS_W-1:0]   pan_r, pan_nxt;
  logic [pta_pkg::POS_W-1:0]   tilt_r, tilt_nxt;
  logic [pta_pkg::SHOT_W-1:0]  shot_r, shot_nxt;
  logic [pta_pkg::MISS_W-1:0]  miss_r, miss_nxt;
  logic                        await_r, await_nxt;
  logic [pta_pkg::MISS_W:0]    miss_inc;
  logic                        done;
  logic                        advance;
  logic                        in_acc;

  logic                        out_vld_r;
  logic [pta_pkg::POS_W-1:0]   out_pan_r;
  logic [pta_pkg::POS_W-1:0]   out_tilt_r;
  logic                        out_pmov_r;
  logic                        out_tmov_r;
  logic                        out_fire_r;
  logic [pta_pkg::SHOT_W-1:0]  out_shot_r;
  logic                        out_fin_r;

  // handshake: the held item moves on when the result register is free
  assign advance     = item_vld_r && (!out_vld_r || out_ch.ready);
  assign in_ch.ready = !item_vld_r || advance;
  assign in_acc      = in_ch.valid && in_ch.ready;

  assign item       = item_r;
  assign pan_pos    = pan_r;
  assign tilt_pos   = tilt_r;
  assign shot_count = shot_r;

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_vld_r <= 1'b0;
    end else if (in_acc) begin
      item_vld_r <= 1'b1;
    end else if (advance) begin
      item_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      item_r.kind       <= in_ch.kind;
      item_r.centroid_x <= in_ch.centroid_x;
      item_r.centroid_y <= in_ch.centroid_y;
    end
  end

  // next tracking state for the held item
  assign done     = shot_r >= pta_pkg::SHOT_W'(pta_pkg::SHOT_TOTAL);
  assign miss_inc = {1'b0, miss_r} + 9'd1;

  always_comb begin
    pan_nxt   = pan_r;
    tilt_nxt  = tilt_r;
    shot_nxt  = shot_r;
    miss_nxt  = miss_r;
    await_nxt = await_r;
    if (!done) begin
      case (pta_pkg::kind_t'(item_r.kind))
        pta_pkg::KIND_TARGET: begin
          if (!await_r) begin
            miss_nxt = '0;
            if (pan_res.in_win && tilt_res.in_win) begin
              await_nxt = 1'b1;
            end else begin
              pan_nxt  = pan_res.move_pos;
              tilt_nxt = tilt_res.move_pos;
            end
          end
        end
        pta_pkg::KIND_MISS: begin
          if (!await_r) begin
            if (miss_inc > {1'b0, lost_limit}) begin
              pan_nxt  = home[pta_pkg::POS_W-1:0];
              tilt_nxt = home[2*pta_pkg::POS_W-1:pta_pkg::POS_W];
              miss_nxt = '0;
            end else begin
              miss_nxt = miss_inc[pta_pkg::MISS_W-1:0];
            end
          end
        end
        pta_pkg::KIND_ACK: begin
          if (await_r) begin
            await_nxt = 1'b0;
            shot_nxt  = shot_r + 2'd1;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // tracking state, home position of the register at reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pan_r   <= pta_pkg::HOME_RST[pta_pkg::POS_W-1:0];
      tilt_r  <= pta_pkg::HOME_RST[2*pta_pkg::POS_W-1:pta_pkg::POS_W];
      shot_r  <= '0;
      miss_r  <= '0;
      await_r <= 1'b0;
    end else if (advance) begin
      pan_r   <= pan_nxt;
      tilt_r  <= tilt_nxt;
      shot_r  <= shot_nxt;
      miss_r  <= miss_nxt;
      await_r <= await_nxt;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (advance) begin
      out_vld_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_pan_r  <= pan_nxt;
      out_tilt_r <= tilt_nxt;
      out_pmov_r <= pan_nxt != pan_r;
      out_tmov_r <= tilt_nxt != tilt_r;
      out_fire_r <= await_nxt;
      out_shot_r <= shot_nxt;
      out_fin_r  <= shot_nxt >= pta_pkg::SHOT_W'(pta_pkg::SHOT_TOTAL);
    end
  end

  assign out_ch.valid        = out_vld_r;
  assign out_ch.pan_command  = out_pan_r;
  assign out_ch.tilt_command = out_tilt_r;
  assign out_ch.pan_moved    = out_pmov_r;
  assign out_ch.tilt_moved   = out_tmov_r;
  assign out_ch.fire_request = out_fire_r;
  assign out_ch.shots_done   = out_shot_r;
  assign out_ch.finished     = out_fin_r;

  // checks
  `PTA_ASSERT_NEXT(a_done_holds, done, $stable(pan_r) && $stable(tilt_r) && $stable(shot_r))
  `PTA_ASSERT_NEXT(a_await_holds, await_r, $stable(pan_r) && $stable(tilt_r))
  `PTA_ASSERT_NEXT(a_adv_result, advance, out_vld_r && (out_fire_r == await_r))
  `PTA_ASSERT_NOW(a_fin_flag, out_vld_r && out_fin_r, !out_fire_r)

endmodule

`default_nettype wire

// ===== sv/pan_tilt_aim_controller_top.sv =====
// Pan/tilt aim controller top: configuration registers, two axis units, controller.
// Data path: an accepted item sits in the input register; its result is registered in the
//   result register once that register is free or being read.
// Throughput: one item per cycle while the receiver keeps taking results.
// Reset (synchronous, rst_n low): registers take their reset values, axes sit at
//   home, shot, miss and fire state clear, both channels empty.
`default_nettype none

module pan_tilt_aim_controller_top (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             cfg_wr_en,
  input  wire logic [pta_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [pta_pkg::CFG_W-1:0]        cfg_wdata,
  pta_in_if.sink                                in_ch,
  pta_out_if.source                             out_ch
);

  logic [23:0] thresh_r;
  logic [15:0] gains_r;
  logic [35:0] aim_x_r;
  logic [35:0] aim_y_r;
  logic [43:0] pan_lim_r;
  logic [43:0] tilt_lim_r;
  logic [43:0] home_r;
  logic [7:0]  lost_r;

  pta_pkg::item_t                item;
  pta_pkg::axis_res_t            pan_res;
  pta_pkg::axis_res_t            tilt_res;
  logic [pta_pkg::POS_W-1:0]     pan_pos;
  logic [pta_pkg::POS_W-1:0]     tilt_pos;
  logic [pta_pkg::SHOT_W-1:0]    shot_count;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thresh_r   <= pta_pkg::THRESH_RST;
      gains_r    <= pta_pkg::GAINS_RST;
      aim_x_r    <= pta_pkg::AIM_RST;
      aim_y_r    <= pta_pkg::AIM_RST;
      pan_lim_r  <= pta_pkg::LIMITS_RST;
      tilt_lim_r <= pta_pkg::LIMITS_RST;
      home_r     <= pta_pkg::HOME_RST;
      lost_r     <= pta_pkg::LOST_RST;
    end else if (cfg_wr_en) begin
      case (pta_pkg::cfg_idx_t'(cfg_index))
        pta_pkg::REG_THRESH:   thresh_r   <= cfg_wdata[23:0];
        pta_pkg::REG_GAINS:    gains_r    <= cfg_wdata[15:0];
        pta_pkg::REG_AIM_X:    aim_x_r    <= cfg_wdata[35:0];
        pta_pkg::REG_AIM_Y:    aim_y_r    <= cfg_wdata[35:0];
        pta_pkg::REG_PAN_LIM:  pan_lim_r  <= cfg_wdata;
        pta_pkg::REG_TILT_LIM: tilt_lim_r <= cfg_wdata;
        pta_pkg::REG_HOME:     home_r     <= cfg_wdata;
        pta_pkg::REG_LOST:     lost_r     <= cfg_wdata[7:0];
        default: begin
        end
      endcase
    end
  end

  // pan axis
  pta_axis u_pan (
    .pos      (pan_pos),
    .aim      (pta_pkg::pick_point(aim_x_r, shot_count)),
    .centroid (item.centroid_x),
    .thresh   (thresh_r[11:0]),
    .gain     (gains_r[7:0]),
    .limits   (pan_lim_r),
    .res      (pan_res)
  );

  // tilt axis
  pta_axis u_tilt (
    .pos      (tilt_pos),
    .aim      (pta_pkg::pick_point(aim_y_r, shot_count)),
    .centroid (item.centroid_y),
    .thresh   (thresh_r[23:12]),
    .gain     (gains_r[15:8]),
    .limits   (tilt_lim_r),
    .res      (tilt_res)
  );

  // controller
  pta_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .out_ch     (out_ch),
    .home       (home_r),
    .lost_limit (lost_r),
    .pan_res    (pan_res),
    .tilt_res   (tilt_res),
    .item       (item),
    .pan_pos    (pan_pos),
    .tilt_pos   (tilt_pos),
    .shot_count (shot_count)
  );

endmodule

`default_nettype wire

// ===== tb/testbench.sv =====
// self-checking testbench for the pan/tilt aim controller top level
`timescale 1ns / 1ps

module testbench;

  localparam int CYCLE_LIMIT = 400000;
  localparam int PRINT_CAP = 100;
  localparam logic [1:0] KIND_UNUSED = 2'd3;
  localparam logic [21:0] POS_MAX = 22'h3FFFFF;

  // expected servo command for one item
  typedef struct packed {
    logic [21:0] pan;
    logic [21:0] tilt;
    logic        pan_moved;
    logic        tilt_moved;
    logic        fire;
    logic [1:0]  shots;
    logic        finished;
  } servo_cmd_t;

  logic clk;
  logic rst_n;
  logic cfg_wr_en;
  pta_pkg::cfg_idx_t cfg_index;
  logic [43:0] cfg_wdata;

  pta_in_if in_bus ();
  pta_out_if out_bus ();

  pan_tilt_aim_controller_top u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_ch     (in_bus),
    .out_ch    (out_bus)
  );

  // register copies, starting from their reset values
  logic [23:0] reg_thresh   = pta_pkg::THRESH_RST;
  logic [15:0] reg_gains    = pta_pkg::GAINS_RST;
  logic [35:0] reg_aim_x    = pta_pkg::AIM_RST;
  logic [35:0] reg_aim_y    = pta_pkg::AIM_RST;
  logic [43:0] reg_pan_lim  = pta_pkg::LIMITS_RST;
  logic [43:0] reg_tilt_lim = pta_pkg::LIMITS_RST;
  logic [43:0] reg_home     = pta_pkg::HOME_RST;
  logic [7:0]  reg_lost     = pta_pkg::LOST_RST;

  // tracked turret state
  logic [21:0] trk_pan    = pta_pkg::HOME_RST[21:0];
  logic [21:0] trk_tilt   = pta_pkg::HOME_RST[43:22];
  logic [1:0]  trk_shots  = 2'd0;
  logic [7:0]  trk_misses = 8'd0;
  logic        trk_armed  = 1'b0;

  servo_cmd_t pending_cmds[$];
  servo_cmd_t want;
  int err_count = 0;
  int cycle_cnt = 0;
  int tx_idle_pct = 17;
  int rx_idle_pct = 70;
  int rx_hold_req = 0;
  int rx_hold_left = 0;

  // clock
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // run length guard
  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("pan_tilt_aim_controller_top test failed");
      $finish;
    end
  end

  task automatic report_mismatch(input string what, input longint unsigned got,
                                 input longint unsigned exp_v);
    if (err_count < PRINT_CAP)
      $display("mismatch %s: got %0h, want %0h at cycle %0d", what, got, exp_v, cycle_cnt);
    err_count++;
  endtask

  function automatic longint abs_l(input longint v);
    return (v < 0) ? -v : v;
  endfunction

  // aim coordinate of the barrel currently in use
  function automatic logic [11:0] barrel_aim(input logic [35:0] pts);
    case (trk_shots)
      2'd1:    return pts[23:12];
      2'd2:    return pts[35:24];
      default: return pts[11:0];
    endcase
  endfunction

  function automatic longint aim_error(input bit tilt_axis, input logic [11:0] c);
    return $signed({1'b0, barrel_aim(tilt_axis ? reg_aim_y : reg_aim_x)}) - $signed({1'b0, c});
  endfunction

  // min wins over max when the two cross
  function automatic logic [21:0] clamp_pos(input longint p, input logic [43:0] lim);
    longint lo;
    longint hi;
    lo = lim[21:0];
    hi = lim[43:22];
    if (p < lo) p = lo;
    else if (p > hi) p = hi;
    return p[21:0];
  endfunction

  // true when a target frame would raise the fire request
  function automatic bit in_window(input logic [11:0] cx, input logic [11:0] cy);
    longint pth;
    longint tth;
    pth = reg_thresh[11:0];
    tth = reg_thresh[23:12];
    return !trk_armed && (trk_shots < pta_pkg::SHOT_TOTAL) &&
           (abs_l(aim_error(1'b0, cx)) < pth) && (abs_l(aim_error(1'b1, cy)) < tth);
  endfunction

  // advance the tracked state by one item and form its servo command
  task automatic predict_servo(input logic [1:0] k, input logic [11:0] cx,
                               input logic [11:0] cy, output servo_cmd_t r);
    logic [21:0] prev_pan;
    logic [21:0] prev_tilt;
    longint pd, td, pth, tth, np, nt;
    logic [8:0] n;
    prev_pan = trk_pan;
    prev_tilt = trk_tilt;
    if (trk_shots < pta_pkg::SHOT_TOTAL) begin
      if (k == pta_pkg::KIND_TARGET && !trk_armed) begin
        pd = aim_error(1'b0, cx);
        td = aim_error(1'b1, cy);
        pth = reg_thresh[11:0];
        tth = reg_thresh[23:12];
        trk_misses = 8'd0;
        if (abs_l(pd) < pth && abs_l(td) < tth) begin
          trk_armed = 1'b1;
        end else begin
          np = trk_pan;
          nt = trk_tilt;
          if (abs_l(pd) > pth) np += longint'($signed(reg_gains[7:0])) * pd;
          if (abs_l(td) > tth) nt += longint'($signed(reg_gains[15:8])) * td;
          trk_pan = clamp_pos(np, reg_pan_lim);
          trk_tilt = clamp_pos(nt, reg_tilt_lim);
        end
      end else if (k == pta_pkg::KIND_MISS && !trk_armed) begin
        n = trk_misses + 9'd1;
        if (n > reg_lost) begin
          trk_pan = reg_home[21:0];
          trk_tilt = reg_home[43:22];
          trk_misses = 8'd0;
        end else begin
          trk_misses = n[7:0];
        end
      end else if (k == pta_pkg::KIND_ACK && trk_armed) begin
        trk_armed = 1'b0;
        trk_shots = trk_shots + 2'd1;
      end
    end
    r.pan = trk_pan;
    r.tilt = trk_tilt;
    r.pan_moved = (trk_pan != prev_pan);
    r.tilt_moved = (trk_tilt != prev_tilt);
    r.fire = trk_armed;
    r.shots = trk_shots;
    r.finished = (trk_shots >= pta_pkg::SHOT_TOTAL);
  endtask

  // send one item, record its expected command once accepted
  task automatic send_item(input logic [1:0] k, input logic [11:0] cx, input logic [11:0] cy);
    servo_cmd_t exp_cmd;
    while ($urandom_range(99) < tx_idle_pct) begin
      in_bus.valid <= 1'b0;
      @(negedge clk);
    end
    in_bus.valid <= 1'b1;
    in_bus.kind <= k;
    in_bus.centroid_x <= cx;
    in_bus.centroid_y <= cy;
    do @(posedge clk); while (!in_bus.ready);
    predict_servo(k, cx, cy, exp_cmd);
    pending_cmds.push_back(exp_cmd);
    @(negedge clk);
  endtask

  // stop offering and let every outstanding command come out
  task automatic drain_results();
    in_bus.valid <= 1'b0;
    while (pending_cmds.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_reg(input pta_pkg::cfg_idx_t idx, input logic [43:0] val);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    @(negedge clk);
    case (idx)
      pta_pkg::REG_THRESH:   reg_thresh = val[23:0];
      pta_pkg::REG_GAINS:    reg_gains = val[15:0];
      pta_pkg::REG_AIM_X:    reg_aim_x = val[35:0];
      pta_pkg::REG_AIM_Y:    reg_aim_y = val[35:0];
      pta_pkg::REG_PAN_LIM:  reg_pan_lim = val;
      pta_pkg::REG_TILT_LIM: reg_tilt_lim = val;
      pta_pkg::REG_HOME:     reg_home = val;
      pta_pkg::REG_LOST:     reg_lost = val[7:0];
      default: ;
    endcase
  endtask

  // random register values, biased toward the extremes
  function automatic logic [11:0] rand_thresh12();
    case ($urandom_range(9))
      0:       return 12'd0;
      1:       return 12'hFFF;
      2, 3:    return 12'($urandom_range(4095));
      default: return 12'($urandom_range(1, 300));
    endcase
  endfunction

  function automatic logic [7:0] rand_gain8();
    case ($urandom_range(9))
      0:       return 8'h7F;
      1:       return 8'h80;
      2:       return 8'h00;
      3:       return 8'hFF;
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  function automatic logic [11:0] rand_pix12();
    case ($urandom_range(6))
      0:       return 12'd0;
      1:       return 12'hFFF;
      default: return 12'($urandom_range(4095));
    endcase
  endfunction

  function automatic logic [21:0] rand_pos22();
    case ($urandom_range(4))
      0:       return 22'd0;
      1:       return POS_MAX;
      default: return 22'($urandom_range(4194303));
    endcase
  endfunction

  function automatic logic [43:0] rand_limits();
    logic [21:0] lo;
    logic [21:0] hi;
    case ($urandom_range(9))
      0: begin
        lo = 22'd0;
        hi = POS_MAX;
      end
      1: begin
        hi = 22'($urandom_range(2000000));
        lo = 22'($urandom_range(2000001, 4194303));
      end
      2: begin
        lo = rand_pos22();
        hi = lo;
      end
      3: begin
        lo = rand_pos22();
        hi = rand_pos22();
      end
      default: begin
        lo = 22'($urandom_range(1500000));
        hi = lo + 22'($urandom_range(100000, 2600000));
      end
    endcase
    return {hi, lo};
  endfunction

  task automatic write_random_config();
    logic [7:0] lost_v;
    case ($urandom_range(9))
      0:       lost_v = 8'd0;
      1:       lost_v = 8'd255;
      2:       lost_v = 8'($urandom_range(7, 60));
      default: lost_v = 8'($urandom_range(1, 6));
    endcase
    drain_results();
    write_reg(pta_pkg::REG_THRESH, 44'({rand_thresh12(), rand_thresh12()}));
    write_reg(pta_pkg::REG_GAINS, 44'({rand_gain8(), rand_gain8()}));
    write_reg(pta_pkg::REG_AIM_X, 44'({rand_pix12(), rand_pix12(), rand_pix12()}));
    write_reg(pta_pkg::REG_AIM_Y, 44'({rand_pix12(), rand_pix12(), rand_pix12()}));
    write_reg(pta_pkg::REG_PAN_LIM, rand_limits());
    write_reg(pta_pkg::REG_TILT_LIM, rand_limits());
    write_reg(pta_pkg::REG_HOME, {rand_pos22(), rand_pos22()});
    write_reg(pta_pkg::REG_LOST, 44'(lost_v));
  endtask

  // keep random targets out of the fire window, sometimes right on its rim
  task automatic steer_target(inout logic [1:0] k, inout logic [11:0] cx,
                              inout logic [11:0] cy);
    int rim;
    int tries;
    if ($urandom_range(3) == 0) begin
      rim = int'(barrel_aim(reg_aim_x)) +
            ($urandom_range(1) ? int'(reg_thresh[11:0]) : -int'(reg_thresh[11:0]));
      if (rim >= 0 && rim <= 4095) cx = 12'(rim);
      if ($urandom_range(1)) begin
        rim = int'(barrel_aim(reg_aim_y)) +
              ($urandom_range(1) ? int'(reg_thresh[23:12]) : -int'(reg_thresh[23:12]));
        if (rim >= 0 && rim <= 4095) cy = 12'(rim);
      end
    end
    tries = 0;
    while (in_window(cx, cy) && tries < 8) begin
      cx = 12'($urandom_range(4095));
      cy = 12'($urandom_range(4095));
      tries++;
    end
    if (in_window(cx, cy)) k = pta_pkg::KIND_MISS;
  endtask

  // random frames and stray items; only frames count toward n_frames
  task automatic run_random_items(input int n_frames);
    int sent;
    int streak;
    int pick;
    logic [1:0] k;
    logic [11:0] cx;
    logic [11:0] cy;
    sent = 0;
    streak = 0;
    while (sent < n_frames) begin
      pick = $urandom_range(99);
      if (streak > 0) begin
        k = pta_pkg::KIND_MISS;
        streak--;
      end else if (pick < 5) begin
        k = pta_pkg::KIND_MISS;
        streak = $urandom_range((reg_lost > 37) ? 40 : int'(reg_lost) + 3);
      end else if (pick < 60) begin
        k = pta_pkg::KIND_TARGET;
      end else if (pick < 82) begin
        k = pta_pkg::KIND_MISS;
      end else if (pick < 91) begin
        k = pta_pkg::KIND_ACK;
      end else begin
        k = KIND_UNUSED;
      end
      cx = 12'($urandom_range(4095));
      cy = 12'($urandom_range(4095));
      if (k == pta_pkg::KIND_TARGET) steer_target(k, cx, cy);
      send_item(k, cx, cy);
      if (k == pta_pkg::KIND_TARGET || k == pta_pkg::KIND_MISS) sent++;
    end
  endtask

  // ignored kinds, a lone acknowledge, then targets and a miss straight out of reset
  task automatic test_reset_behavior();
    send_item(KIND_UNUSED, 12'hFFF, 12'hFFF);
    send_item(pta_pkg::KIND_ACK, 12'd0, 12'd0);
    send_item(pta_pkg::KIND_TARGET, 12'hFFF, 12'hFFF);
    send_item(pta_pkg::KIND_TARGET, 12'd0, 12'hFFF);
    send_item(pta_pkg::KIND_MISS, 12'd0, 12'd0);
  endtask

  // threshold ties, clamping, return home, fire and acknowledge
  task automatic test_edge_cases();
    drain_results();
    write_reg(pta_pkg::REG_THRESH, 44'({12'd7, 12'd5}));
    write_reg(pta_pkg::REG_GAINS, 44'({8'h80, 8'h7F}));
    write_reg(pta_pkg::REG_AIM_X, 44'({12'd3000, 12'd2000, 12'd1000}));
    write_reg(pta_pkg::REG_AIM_Y, 44'({12'd3500, 12'd2500, 12'd1500}));
    write_reg(pta_pkg::REG_PAN_LIM, {POS_MAX, 22'd1000});
    write_reg(pta_pkg::REG_TILT_LIM, {22'd3000000, 22'd500});
    // home tilt sits below the tilt minimum and is taken unclamped
    write_reg(pta_pkg::REG_HOME, {22'd100, 22'd200000});
    write_reg(pta_pkg::REG_LOST, 44'd2);
    send_item(pta_pkg::KIND_TARGET, 12'd0, 12'd0);
    send_item(pta_pkg::KIND_TARGET, 12'd995, 12'd1507);
    send_item(pta_pkg::KIND_TARGET, 12'd995, 12'd1500);
    send_item(pta_pkg::KIND_TARGET, 12'hFFF, 12'd0);
    repeat (3) send_item(pta_pkg::KIND_MISS, 12'hFFF, 12'hFFF);
    // crossed pan limits
    drain_results();
    write_reg(pta_pkg::REG_PAN_LIM, {22'd1000000, 22'd3000000});
    send_item(pta_pkg::KIND_TARGET, 12'd0, 12'd1500);
    send_item(pta_pkg::KIND_TARGET, 12'd0, 12'd1500);
    // fire, frames while waiting, acknowledge, then a stray acknowledge
    send_item(pta_pkg::KIND_TARGET, 12'd1001, 12'd1499);
    send_item(pta_pkg::KIND_TARGET, 12'd0, 12'd0);
    send_item(pta_pkg::KIND_MISS, 12'd0, 12'd0);
    send_item(KIND_UNUSED, 12'd1001, 12'd1499);
    send_item(pta_pkg::KIND_ACK, 12'd0, 12'd0);
    send_item(pta_pkg::KIND_ACK, 12'hFFF, 12'hFFF);
  endtask

  task automatic test_random_settings(input int bursts);
    repeat (bursts) begin
      write_random_config();
      run_random_items(110);
    end
  endtask

  // receiver holds off while the sender keeps offering
  task automatic test_backpressure();
    rx_hold_req = 300;
    run_random_items(40);
  endtask

  // the 256th miss returns home when the limit is at its top
  task automatic test_miss_limit_max();
    drain_results();
    write_reg(pta_pkg::REG_THRESH, 44'd0);
    write_reg(pta_pkg::REG_LOST, 44'd255);
    write_reg(pta_pkg::REG_HOME, {rand_pos22(), rand_pos22()});
    send_item(pta_pkg::KIND_TARGET, 12'($urandom_range(4095)), 12'($urandom_range(4095)));
    repeat (258) send_item(pta_pkg::KIND_MISS, 12'($urandom_range(4095)),
                           12'($urandom_range(4095)));
    send_item(pta_pkg::KIND_TARGET, 12'($urandom_range(4095)), 12'($urandom_range(4095)));
  endtask

  // one shot on the current barrel, with ignored items while it waits
  task automatic test_fire_cycle();
    logic [1:0] k;
    drain_results();
    write_reg(pta_pkg::REG_THRESH,
              44'({($urandom_range(4) == 0) ? 12'hFFF : 12'($urandom_range(1, 4095)),
                   ($urandom_range(4) == 0) ? 12'hFFF : 12'($urandom_range(1, 4095))}));
    send_item(pta_pkg::KIND_TARGET, barrel_aim(reg_aim_x), barrel_aim(reg_aim_y));
    repeat ($urandom_range(2, 6)) begin
      case ($urandom_range(2))
        0:       k = pta_pkg::KIND_TARGET;
        1:       k = pta_pkg::KIND_MISS;
        default: k = KIND_UNUSED;
      endcase
      send_item(k, 12'($urandom_range(4095)), 12'($urandom_range(4095)));
    end
    send_item(pta_pkg::KIND_ACK, 12'($urandom_range(4095)), 12'($urandom_range(4095)));
    send_item(pta_pkg::KIND_ACK, 12'($urandom_range(4095)), 12'($urandom_range(4095)));
  endtask

  // every kind is ignored once all shots are done
  task automatic test_after_finish();
    send_item(pta_pkg::KIND_TARGET, barrel_aim(reg_aim_x), barrel_aim(reg_aim_y));
    repeat (12) send_item(2'($urandom_range(3)), 12'($urandom_range(4095)),
                          12'($urandom_range(4095)));
  endtask

  // receiver ready, with random holds and one long hold on request
  initial begin
    out_bus.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (rx_hold_req > 0) begin
        rx_hold_left = rx_hold_req;
        rx_hold_req = 0;
      end
      if (rx_hold_left > 0) begin
        out_bus.ready <= 1'b0;
        rx_hold_left--;
      end else begin
        out_bus.ready <= ($urandom_range(99) >= rx_idle_pct);
      end
    end
  end

  // compare each command with the oldest expectation
  always @(posedge clk) begin
    if (rst_n && out_bus.valid && out_bus.ready) begin
      if (pending_cmds.size() == 0) begin
        report_mismatch("command with none expected", out_bus.pan_command, 0);
      end else begin
        want = pending_cmds.pop_front();
        if (out_bus.pan_command !== want.pan)
          report_mismatch("pan_command", out_bus.pan_command, want.pan);
        if (out_bus.tilt_command !== want.tilt)
          report_mismatch("tilt_command", out_bus.tilt_command, want.tilt);
        if (out_bus.pan_moved !== want.pan_moved)
          report_mismatch("pan_moved", out_bus.pan_moved, want.pan_moved);
        if (out_bus.tilt_moved !== want.tilt_moved)
          report_mismatch("tilt_moved", out_bus.tilt_moved, want.tilt_moved);
        if (out_bus.fire_request !== want.fire)
          report_mismatch("fire_request", out_bus.fire_request, want.fire);
        if (out_bus.shots_done !== want.shots)
          report_mismatch("shots_done", out_bus.shots_done, want.shots);
        if (out_bus.finished !== want.finished)
          report_mismatch("finished", out_bus.finished, want.finished);
      end
    end
  end

  // test sequence
  initial begin
    rst_n = 1'b0;
    cfg_wr_en = 1'b0;
    cfg_index = pta_pkg::REG_THRESH;
    cfg_wdata = 44'd0;
    in_bus.valid = 1'b0;
    in_bus.kind = pta_pkg::KIND_TARGET;
    in_bus.centroid_x = 12'd0;
    in_bus.centroid_y = 12'd0;
    repeat (2) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    test_reset_behavior();
    test_edge_cases();
    test_random_settings(2);
    test_backpressure();
    test_random_settings(2);

    tx_idle_pct = 70;
    rx_idle_pct = 17;
    test_random_settings(4);
    test_miss_limit_max();
    test_fire_cycle();

    tx_idle_pct = 0;
    rx_idle_pct = 0;
    test_random_settings(4);
    test_fire_cycle();
    test_after_finish();

    drain_results();
    repeat (6) @(negedge clk);
    if (err_count == 0) begin
      $display("pan_tilt_aim_controller_top test passed");
    end else begin
      $display("pan_tilt_aim_controller_top test failed");
    end
    $finish;
  end

endmodule
